### rtl/lzm_pkg.sv
`timescale 1ns / 1ps

package lzm_pkg;

	localparam int unsigned OP_W     = 2;
	localparam int unsigned LAYER_W  = 8;
	localparam int unsigned HGT_W    = 9;
	localparam int unsigned STAT_W   = 2;
	localparam int unsigned COUNT_W  = 9;

	// Wide enough to index 1024 slots.
	localparam int unsigned POS_W    = 10;
	localparam int unsigned VIS_W    = 11;
	localparam int unsigned CW       = 12;

	localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
	localparam logic [OP_W-1:0] OP_SET   = 2'd1;
	localparam logic [OP_W-1:0] OP_FREE  = 2'd2;
	localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

	localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NO_FREE   = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NOT_ALLOC = 2'd2;

	localparam logic signed [CW-1:0] HGT_HIDDEN = '1;

	typedef enum logic [1:0] {
		SH_NONE,
		SH_LEFT,
		SH_RIGHT
	} shift_t;

	typedef struct packed {
		logic               free_hit;
		logic [POS_W-1:0]   free_idx;
		logic               lay_hit;
		logic [POS_W-1:0]   lay_pos;
		logic               lay_used;
	} scan_t;

	typedef struct packed {
		logic [LAYER_W-1:0] lay;
		logic [VIS_W-1:0]   vis;
	} probe_t;

	typedef struct packed {
		shift_t                 shift;
		logic signed [CW-1:0]   sh_lo;
		logic signed [CW-1:0]   sh_hi;
		logic                   wr_en;
		logic [POS_W-1:0]       wr_pos;
		logic [LAYER_W-1:0]     wr_lay;
		logic                   use_set;
		logic                   use_clr;
		logic [POS_W-1:0]       use_slot;
	} cell_cmd_t;

endpackage

### rtl/lzm_if.sv
`timescale 1ns / 1ps

interface lzm_req_if;
	logic                                  valid;
	logic                                  ready;
	logic [lzm_pkg::OP_W-1:0]              opcode;
	logic [lzm_pkg::LAYER_W-1:0]           layer;
	logic signed [lzm_pkg::HGT_W-1:0]      requested_height;

	modport source (output valid, opcode, layer, requested_height, input ready);
	modport sink   (input valid, opcode, layer, requested_height, output ready);
endinterface

interface lzm_rsp_if;
	logic                                  valid;
	logic                                  ready;
	logic [lzm_pkg::STAT_W-1:0]            status;
	logic [lzm_pkg::LAYER_W-1:0]           layer_out;
	logic signed [lzm_pkg::HGT_W-1:0]      new_height;
	logic [lzm_pkg::COUNT_W-1:0]           visible_count;
	logic                                  redraw_valid;
	logic [lzm_pkg::HGT_W-1:0]             map_from;
	logic [lzm_pkg::HGT_W-1:0]             redraw_low;
	logic signed [lzm_pkg::HGT_W-1:0]      redraw_high;

	modport source (output valid, status, layer_out, new_height, visible_count, redraw_valid,
		map_from, redraw_low, redraw_high, input ready);
	modport sink   (input valid, status, layer_out, new_height, visible_count, redraw_valid,
		map_from, redraw_low, redraw_high, output ready);
endinterface

### rtl/lzm_cell.sv
`timescale 1ns / 1ps

module lzm_cell #(
	parameter int unsigned IDX = 0
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lzm_pkg::probe_t              probe,
	input  lzm_pkg::scan_t               scan_in,
	output lzm_pkg::scan_t               scan_out,
	input  lzm_pkg::cell_cmd_t           cmd,
	input  logic [lzm_pkg::LAYER_W-1:0]  left_ord,
	input  logic [lzm_pkg::LAYER_W-1:0]  right_ord,
	output logic [lzm_pkg::LAYER_W-1:0]  ord
);

	localparam logic [lzm_pkg::POS_W-1:0]      IDX_P = lzm_pkg::POS_W'(IDX);
	localparam logic [lzm_pkg::VIS_W-1:0]      IDX_V = lzm_pkg::VIS_W'(IDX);
	localparam logic signed [lzm_pkg::CW-1:0]  IDX_S = lzm_pkg::CW'(IDX);

	logic [lzm_pkg::LAYER_W-1:0] ord_q;
	logic                        use_q;
	lzm_pkg::scan_t              scan_q;
	logic                        active;
	logic                        self_slot;
	logic                        in_rng;

	assign active    = IDX_V < probe.vis;
	assign self_slot = lzm_pkg::POS_W'(probe.lay) == IDX_P;
	assign in_rng    = (IDX_S >= cmd.sh_lo) && (IDX_S <= cmd.sh_hi);

	// The search wave moves one cell to the right in every cycle.
	always_ff @(posedge clk) begin
		scan_q.free_hit <= scan_in.free_hit | ~use_q;
		scan_q.free_idx <= scan_in.free_hit ? scan_in.free_idx : IDX_P;
		scan_q.lay_hit  <= scan_in.lay_hit | (active && (ord_q == probe.lay));
		scan_q.lay_pos  <= scan_in.lay_hit ? scan_in.lay_pos : IDX_P;
		scan_q.lay_used <= scan_in.lay_used | (self_slot & use_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en && (cmd.wr_pos == IDX_P)) begin
			ord_q <= cmd.wr_lay;
		end else if (in_rng && (cmd.shift == lzm_pkg::SH_LEFT)) begin
			ord_q <= left_ord;
		end else if (in_rng && (cmd.shift == lzm_pkg::SH_RIGHT)) begin
			ord_q <= right_ord;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_q <= 1'b0;
		end else if (cmd.use_set && (cmd.use_slot == IDX_P)) begin
			use_q <= 1'b1;
		end else if (cmd.use_clr && (cmd.use_slot == IDX_P)) begin
			use_q <= 1'b0;
		end
	end

	assign scan_out = scan_q;
	assign ord      = ord_q;

endmodule

### rtl/lzm_ctrl.sv
`timescale 1ns / 1ps

module lzm_ctrl #(
	parameter int unsigned LAYERS = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	lzm_req_if.sink              req,
	lzm_rsp_if.source            rsp,
	input  lzm_pkg::scan_t       scan_res,
	output lzm_pkg::probe_t      probe,
	output lzm_pkg::cell_cmd_t   cmd
);

	localparam int unsigned CW = lzm_pkg::CW;
	localparam logic [lzm_pkg::POS_W-1:0] LAST = lzm_pkg::POS_W'(LAYERS - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CALC,
		ST_APPLY
	} state_t;

	state_t                              state_q;
	logic [lzm_pkg::POS_W-1:0]           cnt_q;
	logic [lzm_pkg::OP_W-1:0]            op_q;
	logic [lzm_pkg::LAYER_W-1:0]         lay_q;
	logic signed [lzm_pkg::HGT_W-1:0]    rh_q;
	logic [lzm_pkg::VIS_W-1:0]           vis_q;
	logic signed [CW-1:0]                old_q;
	logic signed [CW-1:0]                h_q;

	logic                                rsp_valid_q;
	logic [lzm_pkg::STAT_W-1:0]          status_q;
	logic [lzm_pkg::LAYER_W-1:0]         layer_out_q;
	logic signed [lzm_pkg::HGT_W-1:0]    new_height_q;
	logic [lzm_pkg::COUNT_W-1:0]         visible_count_q;
	logic                                redraw_valid_q;
	logic [lzm_pkg::HGT_W-1:0]           map_from_q;
	logic [lzm_pkg::HGT_W-1:0]           redraw_low_q;
	logic signed [lzm_pkg::HGT_W-1:0]    redraw_high_q;

	logic signed [CW-1:0]                top_c;
	logic signed [CW-1:0]                old_c;
	logic signed [CW-1:0]                h_c;
	logic                                commit;

	logic [lzm_pkg::STAT_W-1:0]          status_d;
	logic [lzm_pkg::LAYER_W-1:0]         layer_d;
	logic signed [CW-1:0]                new_d;
	logic [lzm_pkg::VIS_W-1:0]           vis_d;
	logic                                redraw_d;
	logic signed [CW-1:0]                mf_d;
	logic signed [CW-1:0]                lo_d;
	logic signed [CW-1:0]                hi_d;
	lzm_pkg::cell_cmd_t                  cmd_d;

	assign top_c  = CW'(vis_q) - CW'(1);
	assign commit = (state_q == ST_APPLY) && (!rsp_valid_q || rsp.ready);

	always_comb begin
		old_c = scan_res.lay_hit ? CW'(scan_res.lay_pos) : lzm_pkg::HGT_HIDDEN;
		h_c   = CW'(rh_q);
		if (h_c > top_c + CW'(1)) begin
			h_c = top_c + CW'(1);
		end
		if ((old_c >= 0) && (h_c > top_c)) begin
			h_c = top_c;
		end
		if (h_c < lzm_pkg::HGT_HIDDEN) begin
			h_c = lzm_pkg::HGT_HIDDEN;
		end
		if (op_q == lzm_pkg::OP_FREE) begin
			h_c = lzm_pkg::HGT_HIDDEN;
		end
	end

	always_comb begin
		cmd_d          = '0;
		cmd_d.shift    = lzm_pkg::SH_NONE;
		cmd_d.wr_lay   = lay_q;
		cmd_d.use_slot = lzm_pkg::POS_W'(lay_q);
		status_d       = lzm_pkg::STAT_OK;
		layer_d        = lay_q;
		new_d          = lzm_pkg::HGT_HIDDEN;
		vis_d          = vis_q;
		redraw_d       = 1'b0;
		mf_d           = '0;
		lo_d           = '0;
		hi_d           = lzm_pkg::HGT_HIDDEN;
		if (op_q == lzm_pkg::OP_ALLOC) begin
			if (scan_res.free_hit) begin
				cmd_d.use_set  = 1'b1;
				cmd_d.use_slot = scan_res.free_idx;
				layer_d        = scan_res.free_idx[lzm_pkg::LAYER_W-1:0];
			end else begin
				status_d = lzm_pkg::STAT_NO_FREE;
				layer_d  = '0;
			end
		end else if ((op_q == lzm_pkg::OP_NONE) || !scan_res.lay_used) begin
			status_d = lzm_pkg::STAT_NOT_ALLOC;
		end else begin
			new_d = h_q;
			cmd_d.use_clr = (op_q == lzm_pkg::OP_FREE);
			if (old_q > h_q) begin
				redraw_d = 1'b1;
				if (h_q >= 0) begin
					cmd_d.shift  = lzm_pkg::SH_LEFT;
					cmd_d.sh_lo  = h_q + CW'(1);
					cmd_d.sh_hi  = old_q;
					cmd_d.wr_en  = 1'b1;
					cmd_d.wr_pos = h_q[lzm_pkg::POS_W-1:0];
					mf_d         = h_q + CW'(1);
					lo_d         = h_q + CW'(1);
					hi_d         = old_q;
				end else begin
					cmd_d.shift = lzm_pkg::SH_RIGHT;
					cmd_d.sh_lo = old_q;
					cmd_d.sh_hi = top_c - CW'(1);
					vis_d       = vis_q - lzm_pkg::VIS_W'(1);
					hi_d        = old_q - CW'(1);
				end
			end else if (old_q < h_q) begin
				redraw_d     = 1'b1;
				cmd_d.wr_en  = 1'b1;
				cmd_d.wr_pos = h_q[lzm_pkg::POS_W-1:0];
				if (old_q >= 0) begin
					cmd_d.shift = lzm_pkg::SH_RIGHT;
					cmd_d.sh_lo = old_q;
					cmd_d.sh_hi = h_q - CW'(1);
				end else begin
					cmd_d.shift = lzm_pkg::SH_LEFT;
					cmd_d.sh_lo = h_q + CW'(1);
					cmd_d.sh_hi = top_c + CW'(1);
					vis_d       = vis_q + lzm_pkg::VIS_W'(1);
				end
				mf_d = h_q;
				lo_d = h_q;
				hi_d = h_q;
			end
		end
	end

	always_comb begin
		cmd = cmd_d;
		if (!commit) begin
			cmd.shift   = lzm_pkg::SH_NONE;
			cmd.wr_en   = 1'b0;
			cmd.use_set = 1'b0;
			cmd.use_clr = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			vis_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						op_q    <= req.opcode;
						lay_q   <= req.layer;
						rh_q    <= req.requested_height;
						cnt_q   <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					cnt_q <= cnt_q + lzm_pkg::POS_W'(1);
					if (cnt_q == LAST) begin
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					old_q   <= old_c;
					h_q     <= h_c;
					state_q <= ST_APPLY;
				end
				ST_APPLY: begin
					if (commit) begin
						status_q        <= status_d;
						layer_out_q     <= layer_d;
						new_height_q    <= new_d[lzm_pkg::HGT_W-1:0];
						visible_count_q <= vis_d[lzm_pkg::COUNT_W-1:0];
						redraw_valid_q  <= redraw_d;
						map_from_q      <= mf_d[lzm_pkg::HGT_W-1:0];
						redraw_low_q    <= lo_d[lzm_pkg::HGT_W-1:0];
						redraw_high_q   <= hi_d[lzm_pkg::HGT_W-1:0];
						vis_q           <= vis_d;
						state_q         <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign req.ready         = (state_q == ST_IDLE);
	assign probe.lay         = lay_q;
	assign probe.vis         = vis_q;

	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = status_q;
	assign rsp.layer_out     = layer_out_q;
	assign rsp.new_height    = new_height_q;
	assign rsp.visible_count = visible_count_q;
	assign rsp.redraw_valid  = redraw_valid_q;
	assign rsp.map_from      = map_from_q;
	assign rsp.redraw_low    = redraw_low_q;
	assign rsp.redraw_high   = redraw_high_q;

endmodule

### rtl/layer_zorder_manager.sv
`timescale 1ns / 1ps

// Channel  Dir  Payload
// req      in   opcode, layer, requested_height
// rsp      out  status, layer_out, new_height, visible_count, redraw_valid,
//               map_from, redraw_low, redraw_high
//
// A request is accepted in ST_IDLE and passes through ST_SCAN, ST_CALC and
// ST_APPLY; the next request is accepted back in ST_IDLE, so requests do not
// overlap. A search wave walks the row of LAYERS cells, one cell per cycle,
// to find the lowest free slot and the height of the addressed layer; ST_CALC
// clamps the height and ST_APPLY shifts the stack in all cells at once.
// Reset clears the slot flags in every cell; no clearing pass is needed.
// A new request is taken while an earlier result waits; the final step stalls
// until that result is taken.

module layer_zorder_manager #(
	parameter int unsigned LAYERS = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	lzm_req_if.sink    req,
	lzm_rsp_if.source  rsp
);

	lzm_pkg::scan_t                chain [LAYERS+1];
	logic [lzm_pkg::LAYER_W-1:0]   ord_w [LAYERS+2];
	lzm_pkg::probe_t               probe;
	lzm_pkg::cell_cmd_t            cmd;

	assign chain[0]         = '0;
	assign ord_w[0]         = '0;
	assign ord_w[LAYERS+1]  = '0;

	for (genvar i = 0; i < LAYERS; i++) begin : g_cell
		lzm_cell #(
			.IDX(i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.probe     (probe),
			.scan_in   (chain[i]),
			.scan_out  (chain[i+1]),
			.cmd       (cmd),
			.left_ord  (ord_w[i]),
			.right_ord (ord_w[i+2]),
			.ord       (ord_w[i+1])
		);
	end

	lzm_ctrl #(
		.LAYERS(LAYERS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp      (rsp),
		.scan_res (chain[LAYERS]),
		.probe    (probe),
		.cmd      (cmd)
	);

endmodule
